FILE: src/hbs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types and constants of the heightmap bilinear sampler: store
// geometry, register map, sequencer states and divider handshake structs.
// ----------------------------------------------------------------------------
package hbs_pkg;

  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int HEIGHT_W    = 16;
  localparam int WORLD_W     = 24;
  localparam int SCALE_W     = 16;
  localparam int SIZE_REG_W  = 7;
  localparam int FRAC_W      = 8;
  localparam int DIVIDEND_W  = 32;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam int MAX_WIDTH_DEF = 64;
  localparam int MAX_DEPTH_DEF = 64;

  localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
  localparam logic [1:0] REG_GRID_DEPTH = 2'd1;
  localparam logic [1:0] REG_CELL_SCALE = 2'd2;

  localparam logic [SIZE_REG_W-1:0] GRID_WIDTH_RST = 7'd64;
  localparam logic [SIZE_REG_W-1:0] GRID_DEPTH_RST = 7'd64;
  localparam logic [SCALE_W-1:0]    CELL_SCALE_RST = 16'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_SIGN,
    S_AXIS,
    S_ADDR,
    S_READ,
    S_STORE,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SCALE_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quot;
    logic                  rem_nz;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: src/hbs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_req_if
// Request channel: one item writes a height entry or queries a position.
// ----------------------------------------------------------------------------
interface hbs_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [11:0]        entry_index;
  logic signed [15:0] entry_height;
  logic signed [23:0] world_x;
  logic signed [23:0] world_z;

  modport source (output valid, output req_type, output entry_index,
                  output entry_height, output world_x, output world_z,
                  input ready);
  modport sink (input valid, input req_type, input entry_index,
                input entry_height, input world_x, input world_z,
                output ready);
endinterface
`default_nettype wire

FILE: src/hbs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_rsp_if
// Result channel: one item carries one interpolated height.
// ----------------------------------------------------------------------------
interface hbs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] height;

  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface
`default_nettype wire

FILE: src/hbs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hbs_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle. Returns the
// quotient and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
module hbs_div (
  input  logic              clk,
  input  logic              rst,
  input  hbs_pkg::div_req_t req,
  output hbs_pkg::div_rsp_t rsp
);
  import hbs_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [SCALE_W-1:0]    rem;
  logic [SCALE_W-1:0]    divisor;
  logic [DIVIDEND_W-1:0] work;
  logic [SCALE_W:0]      cand;
  logic                  ge;
  logic [SCALE_W:0]      diff;

  assign cand = {rem, work[DIVIDEND_W-1]};
  assign ge   = cand >= {1'b0, divisor};
  assign diff = cand - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      work    <= req.dividend;
      rem     <= '0;
      divisor <= req.divisor;
    end else if (busy) begin
      work <= {work[DIVIDEND_W-2:0], ge};
      rem  <= ge ? diff[SCALE_W-1:0] : cand[SCALE_W-1:0];
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = work;
  assign rsp.rem_nz = |rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("divider done held longer than one cycle");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < divisor) else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

FILE: src/heightmap_bilinear_sampler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_top
// Height grid store with bilinear height queries at world positions.
// ----------------------------------------------------------------------------
// A write item stores one entry and the block is ready again at once. For a
// query item each world coordinate goes through the shared bit-serial
// divider, sign fix-up and corner selection, then the four corners are read
// one after the other from the grid memory and the three blends run on one
// shared multiplier. The block takes one item at a time; a finished height
// waits in the output register while the next item is accepted.
// Configuration is read through the APB port; the user is to write it only
// while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_top #(
  parameter int MAX_WIDTH = hbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_DEPTH = hbs_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  hbs_req_if.sink                     req,
  hbs_rsp_if.source                   rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hbs_pkg::PADDR_W-1:0] paddr,
  input  logic [hbs_pkg::PDATA_W-1:0] pwdata,
  output logic [hbs_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import hbs_pkg::*;

  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int DSZ_W  = $clog2(MAX_DEPTH + 1);
  localparam int WIDX_W = $clog2(MAX_WIDTH);
  localparam int DIDX_W = $clog2(MAX_DEPTH);
  localparam int AX_W   = 9;
  localparam int PROD_W = DIDX_W + WSZ_W + 1;

  // Configuration registers.
  logic [SIZE_REG_W-1:0] grid_width;
  logic [SIZE_REG_W-1:0] grid_depth;
  logic [SCALE_W-1:0]    cell_scale;
  logic                  cfg_we;
  logic [1:0]            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= GRID_WIDTH_RST;
      grid_depth <= GRID_DEPTH_RST;
      cell_scale <= CELL_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GRID_WIDTH: grid_width <= pwdata[SIZE_REG_W-1:0];
        REG_GRID_DEPTH: grid_depth <= pwdata[SIZE_REG_W-1:0];
        REG_CELL_SCALE: cell_scale <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_GRID_WIDTH: prdata = PDATA_W'(grid_width);
      REG_GRID_DEPTH: prdata = PDATA_W'(grid_depth);
      REG_CELL_SCALE: prdata = PDATA_W'(cell_scale);
      default:        prdata = '0;
    endcase
  end

  // Saturated sizes and nonzero scale, latched when a query is accepted.
  logic [AX_W-1:0]    gw_ext;
  logic [AX_W-1:0]    gd_ext;
  logic [WSZ_W-1:0]   w_sat;
  logic [DSZ_W-1:0]   d_sat;
  logic [WSZ_W-1:0]   w_q;
  logic [DSZ_W-1:0]   d_q;
  logic [SCALE_W-1:0] s_q;

  assign gw_ext = AX_W'(grid_width);
  assign gd_ext = AX_W'(grid_depth);

  always_comb begin
    if (gw_ext < AX_W'(2)) begin
      w_sat = WSZ_W'(2);
    end else if (gw_ext > AX_W'(MAX_WIDTH)) begin
      w_sat = WSZ_W'(MAX_WIDTH);
    end else begin
      w_sat = WSZ_W'(gw_ext);
    end
    if (gd_ext < AX_W'(2)) begin
      d_sat = DSZ_W'(2);
    end else if (gd_ext > AX_W'(MAX_DEPTH)) begin
      d_sat = DSZ_W'(MAX_DEPTH);
    end else begin
      d_sat = DSZ_W'(gd_ext);
    end
  end

  // Sequencer.
  state_t state;
  state_t state_next;
  logic   in_ready;
  logic   div_start;
  logic   out_load;
  logic   in_accept;
  logic   axis_sel;
  logic [1:0] rcnt;
  logic [1:0] bcnt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_accept = req.valid && in_ready;
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (req.valid && req.req_type) begin
          state_next = S_DIV_START;
        end
      end
      S_DIV_START: begin
        div_start  = 1'b1;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: state_next = S_AXIS;
      S_AXIS: state_next = axis_sel ? S_ADDR : S_DIV_START;
      S_ADDR: state_next = S_READ;
      S_READ: state_next = S_STORE;
      S_STORE: state_next = (rcnt == 2'd3) ? S_MUL : S_ADDR;
      S_MUL: state_next = S_ADD;
      S_ADD: state_next = (bcnt == 2'd2) ? S_OUT : S_MUL;
      S_OUT: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_sel <= 1'b0;
      rcnt     <= '0;
      bcnt     <= '0;
    end else begin
      case (state)
        S_IDLE:  axis_sel <= 1'b0;
        S_AXIS: begin
          axis_sel <= 1'b1;
          rcnt     <= '0;
        end
        S_STORE: begin
          rcnt <= rcnt + 1'b1;
          bcnt <= '0;
        end
        S_ADD:   bcnt <= bcnt + 1'b1;
        default: ;
      endcase
    end
  end

  // Divider operands for the current axis.
  logic signed [WORLD_W-1:0] wx;
  logic signed [WORLD_W-1:0] wz;
  logic signed [WORLD_W-1:0] cur_world;
  logic [WORLD_W-1:0]        cur_mag;

  assign cur_world = axis_sel ? wz : wx;
  assign cur_mag   = cur_world[WORLD_W-1] ? WORLD_W'(-cur_world) : WORLD_W'(cur_world);

  assign div_req.start    = div_start;
  assign div_req.dividend = {cur_mag, {FRAC_W{1'b0}}};
  assign div_req.divisor  = s_q;

  hbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (in_accept && req.req_type) begin
      wx  <= req.world_x;
      wz  <= req.world_z;
      w_q <= w_sat;
      d_q <= d_sat;
      s_q <= (cell_scale == '0) ? SCALE_W'(1) : cell_scale;
    end
  end

  // Grid coordinate and corner selection.
  logic signed [DIVIDEND_W:0]   t;
  logic [DIVIDEND_W:0]          q_ext;
  logic signed [DIVIDEND_W-8:0] ti;
  logic [AX_W-1:0]              size_m1;
  logic [AX_W-1:0]              lo9;
  logic [AX_W-1:0]              hi9;
  logic [FRAC_W-1:0]            f_ax;
  logic [WIDX_W-1:0]            x_lo;
  logic [WIDX_W-1:0]            x_hi;
  logic [DIDX_W-1:0]            z_lo;
  logic [DIDX_W-1:0]            z_hi;
  logic [FRAC_W-1:0]            fx;
  logic [FRAC_W-1:0]            fz;

  assign q_ext   = {1'b0, div_rsp.quot};
  assign ti      = t[DIVIDEND_W:FRAC_W];
  assign size_m1 = axis_sel ? (AX_W'(d_q) - AX_W'(1)) : (AX_W'(w_q) - AX_W'(1));

  always_comb begin
    if (t[DIVIDEND_W]) begin
      lo9  = '0;
      hi9  = '0;
      f_ax = '0;
    end else if (ti[DIVIDEND_W-9:0] >= (DIVIDEND_W-8)'(size_m1)) begin
      lo9  = size_m1;
      hi9  = size_m1;
      f_ax = '0;
    end else begin
      lo9  = ti[AX_W-1:0];
      hi9  = ti[AX_W-1:0] + AX_W'(1);
      f_ax = t[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SIGN) begin
      t <= cur_world[WORLD_W-1] ? -(q_ext + (DIVIDEND_W+1)'(div_rsp.rem_nz)) : q_ext;
    end
    if (state == S_AXIS) begin
      if (axis_sel) begin
        z_lo <= DIDX_W'(lo9);
        z_hi <= DIDX_W'(hi9);
        fz   <= f_ax;
      end else begin
        x_lo <= WIDX_W'(lo9);
        x_hi <= WIDX_W'(hi9);
        fx   <= f_ax;
      end
    end
  end

  // Grid memory and corner reads.
  logic signed [HEIGHT_W-1:0] mem [0:STORE_DEPTH-1];
  logic signed [HEIGHT_W-1:0] rd_data;
  logic [ADDR_W-1:0]          rd_addr;
  logic [DIDX_W-1:0]          row;
  logic [WIDX_W-1:0]          col;
  logic [PROD_W-1:0]          lin;
  logic signed [HEIGHT_W-1:0] hv [0:3];

  assign row = rcnt[1] ? z_hi : z_lo;
  assign col = rcnt[0] ? x_hi : x_lo;
  assign lin = PROD_W'(row) * PROD_W'(w_q) + PROD_W'(col);

  always_ff @(posedge clk) begin
    if (in_accept && !req.req_type) begin
      mem[req.entry_index] <= req.entry_height;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      rd_addr <= ADDR_W'(lin);
    end
    if (state == S_STORE) begin
      hv[rcnt] <= rd_data;
    end
  end

  // Blends on one shared multiplier.
  logic signed [HEIGHT_W-1:0] bl0;
  logic signed [HEIGHT_W-1:0] bl1;
  logic signed [HEIGHT_W-1:0] a_sel;
  logic signed [HEIGHT_W-1:0] b_sel;
  logic [FRAC_W-1:0]          f_sel;
  logic signed [HEIGHT_W:0]   diff;
  logic signed [25:0]         prod;
  logic signed [25:0]         prod_next;
  logic signed [HEIGHT_W+1:0] sum;
  logic signed [HEIGHT_W-1:0] out_height;
  logic                       out_valid;

  always_comb begin
    case (bcnt)
      2'd0: begin
        a_sel = hv[0];
        b_sel = hv[1];
        f_sel = fx;
      end
      2'd1: begin
        a_sel = hv[2];
        b_sel = hv[3];
        f_sel = fx;
      end
      default: begin
        a_sel = bl0;
        b_sel = bl1;
        f_sel = fz;
      end
    endcase
  end

  assign diff      = (HEIGHT_W+1)'(b_sel) - (HEIGHT_W+1)'(a_sel);
  assign prod_next = 26'(diff) * 26'($signed({1'b0, f_sel}));
  assign sum       = (HEIGHT_W+2)'(a_sel) + (HEIGHT_W+2)'(prod >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= prod_next;
    end
    if (state == S_ADD) begin
      case (bcnt)
        2'd0:    bl0 <= sum[HEIGHT_W-1:0];
        2'd1:    bl1 <= sum[HEIGHT_W-1:0];
        default: ;
      endcase
    end
    if (out_load) begin
      out_height <= sum[HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.height = out_height;

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !req.req_type && !rsp.valid) |=> !rsp.valid)
    else $error("write item produced a result");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == S_DIV_WAIT)
    else $error("divider finished outside its wait state");
  a_corner_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> ((x_hi < w_q) && (z_hi < d_q) && (x_lo <= x_hi) && (z_lo <= z_hi)))
    else $error("corner index outside the grid");
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_accept && req.req_type) |=> (state == S_DIV_START && !req.ready))
    else $error("query item did not start the sequencer");

endmodule
`default_nettype wire
